>>> hdl/samc_pkg.sv
// Shared types and constants for the stepper axis motion controller.
package samc_pkg;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0,
    OP_JOG  = 3'd1,
    OP_GOTO = 3'd2,
    OP_HOME = 3'd3,
    OP_STOP = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OVER = 2'd1,
    PH_APPR = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_HIT   = 2'd1,
    EV_RANGE = 2'd2
  } home_ev_t;

  typedef enum logic [2:0] {
    REG_MIN_JOG   = 3'd0,
    REG_MAX_SPEED = 3'd1,
    REG_DEF_GOTO  = 3'd2,
    REG_BACKLASH  = 3'd3,
    REG_HOME_SPD  = 3'd4,
    REG_HOME_NEG  = 3'd5,
    REG_HOME_RNG  = 3'd6,
    REG_INV_DIR   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SEQ,
    S_HOME,
    S_VEL,
    S_DINIT,
    S_DIV,
    S_STEP,
    S_OUT
  } state_t;

  localparam int unsigned QW = 20;            // quotient width of 1e6 / |v|
  localparam logic [QW-1:0] US_PER_S = 20'd1000000;
  localparam logic [QW-1:0] MIN_DELAY = 20'd250;
  localparam logic [QW-1:0] DIV_LAST = 20'd19; // step count of the divider, less one
  localparam int unsigned SLEW = 2;

  typedef struct packed {
    logic load_in;
    logic exec_op;
    logic do_seq;
    logic do_home;
    logic do_vel;
    logic div_init;
    logic div_step;
    logic do_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic vel_nz;
    logic div_last;
  } stat_t;

endpackage

>>> hdl/samc_ctrl.sv
// Sequencing state machine for the stepper axis controller.
module samc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              m_tready,
  input  samc_pkg::stat_t   stat,
  output logic              s_tready,
  output logic              m_tvalid,
  output samc_pkg::cmd_t    cmd
);

  samc_pkg::state_t state, state_next;
  logic out_go;

  assign s_tready = (state == samc_pkg::S_IDLE);
  assign out_go   = (state == samc_pkg::S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= samc_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      samc_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd.load_in = 1'b1;
          state_next = samc_pkg::S_EXEC;
        end
      end
      samc_pkg::S_EXEC: begin
        if (stat.is_tick) begin
          state_next = samc_pkg::S_SEQ;
        end else begin
          cmd.exec_op = 1'b1;
          state_next = samc_pkg::S_OUT;
        end
      end
      samc_pkg::S_SEQ: begin
        cmd.do_seq = 1'b1;
        state_next = samc_pkg::S_HOME;
      end
      samc_pkg::S_HOME: begin
        cmd.do_home = 1'b1;
        state_next = samc_pkg::S_VEL;
      end
      samc_pkg::S_VEL: begin
        cmd.do_vel = 1'b1;
        state_next = samc_pkg::S_DINIT;
      end
      samc_pkg::S_DINIT: begin
        if (stat.vel_nz) begin
          cmd.div_init = 1'b1;
          state_next = samc_pkg::S_DIV;
        end else begin
          state_next = samc_pkg::S_OUT;
        end
      end
      samc_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = samc_pkg::S_STEP;
        end
      end
      samc_pkg::S_STEP: begin
        cmd.do_step = 1'b1;
        state_next = samc_pkg::S_OUT;
      end
      samc_pkg::S_OUT: begin
        if (out_go) begin
          cmd.load_out = 1'b1;
          state_next = samc_pkg::S_IDLE;
        end
      end
      default: state_next = samc_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (state == samc_pkg::S_DIV && !stat.div_last) |=> state == samc_pkg::S_DIV)
    else $error("divider left early");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("input taken while busy");
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("result not presented");
  a_step_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.do_step |-> $past(state) == samc_pkg::S_DIV)
    else $error("step without delay");
`endif

endmodule

>>> hdl/samc_dp.sv
// Axis state, config registers, step delay divider and result register.
module samc_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [30:0]       cfg_data,
  input  logic [2:0]        in_op,
  input  logic [95:0]       in_data,
  input  samc_pkg::cmd_t    cmd,
  output samc_pkg::stat_t   stat,
  output logic [55:0]       out_data
);

  localparam int unsigned QW_M1 = samc_pkg::QW - 1;

  // config
  logic [14:0] min_jog, max_spd, def_goto, home_spd;
  logic [15:0] backlash;
  logic        home_neg, inv_dir;
  logic [30:0] home_rng;

  // latched input beat
  logic [2:0]         op;
  logic [31:0]        now_us;
  logic               endstop;
  logic signed [15:0] jog;
  logic signed [31:0] goal;
  logic [14:0]        gspeed;

  // axis state
  logic signed [31:0] pos, final_goal, interim;
  logic signed [15:0] vel, wanted;
  logic [31:0]        last_stamp, origin;
  samc_pkg::phase_t   phase;
  logic               goto_act, homing;
  logic [14:0]        goto_spd;
  logic               pulse, refused;
  samc_pkg::home_ev_t event_code;

  // divider
  logic [QW_M1:0] quo;
  logic [15:0]    rem;
  logic [14:0]    dsor;
  logic [4:0]     dcnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_jog  <= 15'd10;
      max_spd  <= 15'd4000;
      def_goto <= 15'd1000;
      backlash <= 16'd50;
      home_spd <= 15'd200;
      home_neg <= 1'b1;
      home_rng <= 31'd100000;
      inv_dir  <= 1'b0;
    end else if (cfg_we) begin
      case (samc_pkg::reg_idx_t'(cfg_index))
        samc_pkg::REG_MIN_JOG:   min_jog  <= cfg_data[14:0];
        samc_pkg::REG_MAX_SPEED: max_spd  <= cfg_data[14:0];
        samc_pkg::REG_DEF_GOTO:  def_goto <= cfg_data[14:0];
        samc_pkg::REG_BACKLASH:  backlash <= cfg_data[15:0];
        samc_pkg::REG_HOME_SPD:  home_spd <= cfg_data[14:0];
        samc_pkg::REG_HOME_NEG:  home_neg <= cfg_data[0];
        samc_pkg::REG_HOME_RNG:  home_rng <= cfg_data;
        samc_pkg::REG_INV_DIR:   inv_dir  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---- combinational helpers ----
  logic signed [15:0] home_vel;
  assign home_vel = home_neg ? -$signed({1'b0, home_spd}) : $signed({1'b0, home_spd});

  // jog clamp
  logic [16:0]        jmag, jclamp;
  logic signed [16:0] jsigned;
  always_comb begin
    jmag = jog[15] ? 17'(-$signed({jog[15], jog})) : {1'b0, jog};
    jclamp = jmag;
    if (jmag != 17'd0) begin
      if (jmag < {2'b0, min_jog}) jclamp = {2'b0, min_jog};
      else if (jmag > {2'b0, max_spd}) jclamp = {2'b0, max_spd};
    end
    jsigned = jog[15] ? -$signed(jclamp) : $signed(jclamp);
  end

  // goto setup
  logic [14:0]        gsp;
  logic signed [32:0] over_g;
  logic signed [31:0] over_sat;
  always_comb begin
    gsp = (gspeed != 15'd0) ? gspeed : def_goto;
    if (gsp > max_spd) gsp = max_spd;
    over_g = $signed({goal[31], goal}) - $signed({17'd0, backlash});
    over_sat = (over_g[32] != over_g[31]) ? 32'sh80000000 : over_g[31:0];
  end

  // goto sequencer
  samc_pkg::phase_t   sq_phase;
  logic signed [31:0] sq_interim, sq_pos;
  logic signed [15:0] sq_wanted, sq_vel;
  always_comb begin
    sq_phase = phase;
    sq_interim = interim;
    sq_pos = pos;
    sq_wanted = 16'sd0;
    sq_vel = vel;
    if (phase == samc_pkg::PH_OVER || phase == samc_pkg::PH_APPR) begin
      if (pos == interim) begin
        if (phase == samc_pkg::PH_OVER) begin
          sq_phase = samc_pkg::PH_APPR;
          sq_interim = final_goal;
        end else begin
          sq_pos = final_goal;
          sq_vel = 16'sd0;
          sq_phase = samc_pkg::PH_DONE;
        end
      end
      if (sq_phase != samc_pkg::PH_DONE) begin
        if (sq_pos < sq_interim) sq_wanted = $signed({1'b0, goto_spd});
        else if (sq_pos > sq_interim) sq_wanted = -$signed({1'b0, goto_spd});
        else begin
          // reached the final goal straight after overshoot
          sq_pos = final_goal;
          sq_vel = 16'sd0;
          sq_phase = samc_pkg::PH_DONE;
        end
      end
    end
  end

  // homing distance
  logic [31:0] hd_raw, hd;
  logic        hd_over;
  always_comb begin
    hd_raw = pos - origin;
    hd = hd_raw[31] ? (32'd0 - hd_raw) : hd_raw;
    hd_over = hd >= {1'b0, home_rng};
  end

  // slew
  logic signed [16:0] vdiff;
  logic signed [15:0] vel_new;
  logic               running;
  always_comb begin
    running = goto_act && (phase == samc_pkg::PH_OVER || phase == samc_pkg::PH_APPR);
    vdiff = $signed({wanted[15], wanted}) - $signed({vel[15], vel});
    if (running || wanted == 16'sd0) vel_new = wanted;
    else if (vdiff > 17'sd2) vel_new = vel + 16'sd2;
    else if (vdiff < -17'sd2) vel_new = vel - 16'sd2;
    else vel_new = wanted;
  end

  // divider step and step delay
  logic [16:0]    rsh;
  logic           rge;
  logic [QW_M1:0] delay;
  logic [31:0]    elapsed;
  always_comb begin
    rsh = {rem, quo[QW_M1]};
    rge = rsh >= {2'b0, dsor};
    delay = (quo < samc_pkg::MIN_DELAY) ? samc_pkg::MIN_DELAY : quo;
    elapsed = now_us - last_stamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      vel        <= '0;
      wanted     <= '0;
      last_stamp <= '0;
      phase      <= samc_pkg::PH_IDLE;
      goto_act   <= 1'b0;
      final_goal <= '0;
      interim    <= '0;
      goto_spd   <= '0;
      homing     <= 1'b0;
      origin     <= '0;
    end else begin
      if (cmd.exec_op) begin
        case (samc_pkg::op_t'(op))
          samc_pkg::OP_JOG: begin
            if (!homing) begin
              goto_act <= 1'b0;
              wanted   <= jsigned[15:0];
            end
          end
          samc_pkg::OP_GOTO: begin
            final_goal <= goal;
            goto_spd   <= gsp;
            if (pos == goal) begin
              phase   <= samc_pkg::PH_DONE;
              interim <= goal;
            end else if (pos < goal) begin
              phase   <= samc_pkg::PH_APPR;
              interim <= goal;
            end else begin
              phase   <= samc_pkg::PH_OVER;
              interim <= over_sat;
            end
            goto_act <= 1'b1;
            vel      <= '0;
            wanted   <= '0;
          end
          samc_pkg::OP_HOME: begin
            phase    <= samc_pkg::PH_IDLE;
            goto_act <= 1'b0;
            homing   <= 1'b1;
            origin   <= pos;
            wanted   <= home_vel;
          end
          samc_pkg::OP_STOP: begin
            wanted   <= '0;
            phase    <= samc_pkg::PH_IDLE;
            goto_act <= 1'b0;
            homing   <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.do_seq && goto_act) begin
        phase   <= sq_phase;
        interim <= sq_interim;
        pos     <= sq_pos;
        wanted  <= sq_wanted;
        vel     <= sq_vel;
        if (sq_phase == samc_pkg::PH_DONE) goto_act <= 1'b0;
      end
      if (cmd.do_home && homing) begin
        if (hd_over || !endstop) begin
          pos    <= '0;
          vel    <= '0;
          wanted <= '0;
          homing <= 1'b0;
        end else begin
          wanted <= home_vel;
        end
      end
      if (cmd.do_vel) vel <= vel_new;
      if (cmd.do_step && elapsed >= {12'd0, delay}) begin
        pos        <= vel[15] ? pos - 32'sd1 : pos + 32'sd1;
        last_stamp <= now_us;
      end
    end
  end

  // input latch, per-beat flags, divider and result register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op      <= in_op;
      now_us  <= in_data[31:0];
      endstop <= in_data[32];
      jog     <= in_data[48:33];
      goal    <= in_data[80:49];
      gspeed  <= in_data[95:81];
      pulse      <= 1'b0;
      refused    <= 1'b0;
      event_code <= samc_pkg::EV_NONE;
    end
    if (cmd.exec_op && samc_pkg::op_t'(op) == samc_pkg::OP_JOG && homing) refused <= 1'b1;
    if (cmd.do_home && homing && (hd_over || !endstop)) begin
      event_code <= hd_over ? samc_pkg::EV_RANGE : samc_pkg::EV_HIT;
    end
    if (cmd.do_step && elapsed >= {12'd0, delay}) pulse <= 1'b1;
    if (cmd.div_init) begin
      quo  <= samc_pkg::US_PER_S;
      rem  <= '0;
      dsor <= vel[15] ? 15'(-vel) : vel[14:0];
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= rge ? 16'(rsh - {2'b0, dsor}) : rsh[15:0];
      quo  <= {quo[QW_M1-1:0], rge};
      dcnt <= dcnt + 5'd1;
    end
    if (cmd.load_out) begin
      out_data <= {refused, event_code, homing, phase, vel, pos,
                   (!vel[15] && vel != 16'sd0) ^ inv_dir, pulse};
    end
  end

  assign stat.is_tick  = (samc_pkg::op_t'(op) == samc_pkg::OP_TICK);
  assign stat.vel_nz   = (vel != 16'sd0);
  assign stat.div_last = ({15'd0, dcnt} == samc_pkg::DIV_LAST);

endmodule

>>> hdl/stepper_axis_motion_controller_top.sv
// Top level of the stepper axis motion controller.
// One stepper axis driven by command beats: tick (time and endstop level), jog, goto,
// home and stop. Every input beat yields exactly one result beat with the step pulse,
// direction level, position, velocity, goto phase and homing status. A tick walks the
// goto sequencer, homing check and velocity slew, then works out the step delay
// 1e6/|v| us (floor 250 us) in a bit-serial restoring divider; a tick with nonzero
// velocity runs the divider and then the step check, a tick at rest skips both, and
// the other commands go straight to the result. One beat is in work at a time; a
// finished result sits in the output register so the next beat can be taken while it waits.
// Config writes are taken any time but must only be made while the block is idle.
module stepper_axis_motion_controller_top (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_us[31:0], endstop_level[32], jog_velocity[48:33],
  // goal_position[80:49], goal_speed[95:81]
  input  logic [95:0] s_tdata,
  input  logic [2:0]  s_tuser,   // op[2:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // step_pulse[0], dir_level[1], position_now[33:2], velocity_now[49:34],
  // goto_phase[51:50], homing_busy[52], homing_event[54:53], command_refused[55]
  output logic [55:0] m_tdata
);

  samc_pkg::cmd_t  cmd;
  samc_pkg::stat_t stat;
  logic            in_fire;

  assign in_fire = s_tvalid && s_tready;

  samc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .m_tready (m_tready),
    .stat     (stat),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  samc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_tdata)
  );

endmodule

>>> sim/tb.sv
// Self-checking testbench for the stepper axis motion controller top level.
`timescale 1ns / 1ps

module tb;

  // Expected-result store plus a cycle-free model of the axis
  class axis_scoreboard;
    logic [55:0] want_q[$];
    int errors = 0;
    // configuration
    int unsigned min_jog = 10, max_spd = 4000, def_goto = 1000, backlash = 50;
    int unsigned home_spd = 200, home_neg = 1, home_rng = 100000, inv_dir = 0;
    // axis state
    bit [31:0] pos, stamp, horig;
    int vel, wvel, fgoal, igoal, gspd;
    samc_pkg::phase_t ph = samc_pkg::PH_IDLE;
    bit gact, hflag;

    function void set_reg(samc_pkg::reg_idx_t idx, int unsigned v);
      case (idx)
        samc_pkg::REG_MIN_JOG:   min_jog  = v & 32'h7FFF;
        samc_pkg::REG_MAX_SPEED: max_spd  = v & 32'h7FFF;
        samc_pkg::REG_DEF_GOTO:  def_goto = v & 32'h7FFF;
        samc_pkg::REG_BACKLASH:  backlash = v & 32'hFFFF;
        samc_pkg::REG_HOME_SPD:  home_spd = v & 32'h7FFF;
        samc_pkg::REG_HOME_NEG:  home_neg = v & 1;
        samc_pkg::REG_HOME_RNG:  home_rng = v & 32'h7FFF_FFFF;
        samc_pkg::REG_INV_DIR:   inv_dir  = v & 1;
        default: ;
      endcase
    endfunction

    function int home_vel();
      return home_neg ? -int'(home_spd) : int'(home_spd);
    endfunction

    function void seq_adv();
      if ($signed(pos) != igoal) return;
      if (ph == samc_pkg::PH_OVER) begin
        ph = samc_pkg::PH_APPR;
        igoal = fgoal;
      end else if (ph == samc_pkg::PH_APPR) begin
        pos = fgoal;
        wvel = 0;
        vel = 0;
        ph = samc_pkg::PH_DONE;
      end
    endfunction

    function void seq_upd();
      if (ph == samc_pkg::PH_IDLE || ph == samc_pkg::PH_DONE) begin
        wvel = 0;
        return;
      end
      seq_adv();
      if (ph == samc_pkg::PH_DONE) begin
        wvel = 0;
        return;
      end
      if ($signed(pos) < igoal) wvel = gspd;
      else if ($signed(pos) > igoal) wvel = -gspd;
      else begin
        wvel = 0;
        seq_adv();
      end
    endfunction

    // model one accepted command beat and queue its result
    function void note_cmd(logic [2:0] op, logic [95:0] d);
      bit [31:0] now_us, hdist;
      bit endstop, pulse, refused, running;
      int jog, goal, mag, diff;
      int unsigned sp, delay;
      longint g;
      logic [1:0] ev;
      now_us = d[31:0];
      endstop = d[32];
      jog = $signed(d[48:33]);
      goal = $signed(d[80:49]);
      pulse = 0; refused = 0; ev = samc_pkg::EV_NONE;
      case (op)
        samc_pkg::OP_JOG: begin
          if (hflag) refused = 1;
          else begin
            mag = jog < 0 ? -jog : jog;
            gact = 0;
            if (mag != 0) begin
              if (mag < int'(min_jog)) mag = min_jog;
              else if (mag > int'(max_spd)) mag = max_spd;
              jog = jog < 0 ? -mag : mag;
            end
            wvel = jog;
          end
        end
        samc_pkg::OP_GOTO: begin
          sp = d[95:81] != 0 ? d[95:81] : def_goto;
          if (sp > max_spd) sp = max_spd;
          fgoal = goal;
          gspd = sp;
          if ($signed(pos) == goal) begin
            ph = samc_pkg::PH_DONE; igoal = goal;
          end else if ($signed(pos) < goal) begin
            ph = samc_pkg::PH_APPR; igoal = goal;
          end else begin
            g = longint'(goal) - longint'(backlash);
            if (g < -64'sd2147483648) g = -64'sd2147483648;
            ph = samc_pkg::PH_OVER;
            igoal = int'(g);
          end
          gact = 1;
          vel = 0;
          wvel = 0;
        end
        samc_pkg::OP_HOME, samc_pkg::OP_STOP: begin
          wvel = 0; ph = samc_pkg::PH_IDLE; gact = 0; hflag = 0;
          if (op == samc_pkg::OP_HOME) begin
            hflag = 1;
            horig = pos;
            wvel = home_vel();
          end
        end
        samc_pkg::OP_TICK: begin
          if (gact) begin
            seq_upd();
            if (ph == samc_pkg::PH_DONE) gact = 0;
          end
          if (hflag) begin
            hdist = pos - horig;
            if (hdist[31]) hdist = -hdist;
            if (hdist >= home_rng || !endstop) begin
              ev = (hdist >= home_rng) ? samc_pkg::EV_RANGE : samc_pkg::EV_HIT;
              pos = 0; vel = 0; wvel = 0; hflag = 0;
            end else wvel = home_vel();
          end
          running = gact && ph != samc_pkg::PH_IDLE && ph != samc_pkg::PH_DONE;
          if (running || wvel == 0) vel = wvel;
          else begin
            diff = wvel - vel;
            if (diff > 2) vel += 2;
            else if (diff < -2) vel -= 2;
            else vel = wvel;
          end
          if (vel != 0) begin
            delay = 1000000 / (vel < 0 ? -vel : vel);
            if (delay < 250) delay = 250;
            if (now_us - stamp >= delay) begin
              pulse = 1;
              pos = vel > 0 ? pos + 1 : pos - 1;
              stamp = now_us;
            end
          end
        end
        default: ;  // unused codes only report status
      endcase
      want_q.push_back({refused, ev, hflag, ph, vel[15:0], pos, bit'(vel > 0) ^ inv_dir[0],
                        pulse});
    endfunction

    function void check_fld(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [55:0] r);
      logic [55:0] e;
      if (want_q.size() == 0) begin
        $error("result beat with nothing outstanding: %h", r);
        errors++;
        return;
      end
      e = want_q.pop_front();
      check_fld("step_pulse", e[0], r[0]);
      check_fld("dir_level", e[1], r[1]);
      check_fld("position_now", e[33:2], r[33:2]);
      check_fld("velocity_now", e[49:34], r[49:34]);
      check_fld("goto_phase", e[51:50], r[51:50]);
      check_fld("homing_busy", e[52], r[52]);
      check_fld("homing_event", e[54:53], r[54:53]);
      check_fld("command_refused", e[55], r[55]);
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic        s_tvalid = 0, s_tready;
  logic [95:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid, m_tready = 0;
  logic [55:0] m_tdata;

  axis_scoreboard sb = new();
  bit [31:0] t_now = 0;     // running microsecond clock fed on ticks
  int  n_items = 0;
  bit  calm = 0;            // suppress random idling on both sides
  bit  hold_req = 0;        // ask the receiver for a long hold-off

  stepper_axis_motion_controller_top dut (.*);

  initial forever #4 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #8ms;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (hold_req && hold == 0) begin
        hold = 400;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 0;
      end else m_tready <= rst ? 0 : (calm || $urandom_range(99) >= 10);
    end
  end

  // one command beat; waits for the handshake
  task automatic send_beat(logic [2:0] op, logic [95:0] d);
    while (!calm && $urandom_range(99) < 10) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_cmd(op, d);
    n_items++;
  endtask

  // unused fields are filled with noise so that every bit toggles
  function automatic logic [95:0] noise();
    return {$urandom(), $urandom(), $urandom()};
  endfunction

  task automatic tick(bit endstop);
    logic [95:0] d;
    d = noise();
    if ($urandom_range(99) < 3) t_now = $urandom();
    else t_now += $urandom_range(100, 2500);
    d[31:0] = t_now;
    d[32] = endstop;
    send_beat(samc_pkg::OP_TICK, d);
  endtask

  task automatic jog(int v);
    logic [95:0] d;
    d = noise();
    d[48:33] = v[15:0];
    send_beat(samc_pkg::OP_JOG, d);
  endtask

  task automatic goto_pos(int goal, int unsigned spd);
    logic [95:0] d;
    d = noise();
    d[80:49] = goal;
    d[95:81] = spd[14:0];
    send_beat(samc_pkg::OP_GOTO, d);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);   // margin for the longest tick
  endtask

  task automatic write_reg(samc_pkg::reg_idx_t idx, int unsigned v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v[30:0];
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_all(int unsigned mj, ms, dg, bl, hs, hn, hr, inv);
    write_reg(samc_pkg::REG_MIN_JOG, mj);
    write_reg(samc_pkg::REG_MAX_SPEED, ms);
    write_reg(samc_pkg::REG_DEF_GOTO, dg);
    write_reg(samc_pkg::REG_BACKLASH, bl);
    write_reg(samc_pkg::REG_HOME_SPD, hs);
    write_reg(samc_pkg::REG_HOME_NEG, hn);
    write_reg(samc_pkg::REG_HOME_RNG, hr);
    write_reg(samc_pkg::REG_INV_DIR, inv);
  endtask

  // one random scenario; mostly well-formed command runs with random content
  task automatic scenario();
    int k, n;
    k = $urandom_range(9);
    if (k < 3) begin
      case ($urandom_range(3))
        0: jog($urandom_range(65535));
        1: jog($urandom_range(30) - 15);
        default: jog($urandom_range(8000) - 4000);
      endcase
      n = $urandom_range(5, 30);
      repeat (n) tick($urandom_range(1) != 0);
    end else if (k < 6) begin
      goto_pos($signed(sb.pos) + $urandom_range(300) - 150,
               $urandom_range(3) == 0 ? 0 : $urandom_range(32767));
      n = 0;
      while (sb.ph != samc_pkg::PH_DONE && n < 120) begin
        tick($urandom_range(1) != 0);
        n++;
      end
      tick(1);
    end else if (k < 8) begin
      send_beat(samc_pkg::OP_HOME, noise());
      if ($urandom_range(4) == 0) jog($urandom_range(65535));
      n = $urandom_range(1, 40);
      repeat (n) tick($urandom_range(9) != 0);
    end else begin
      send_beat(3'($urandom_range(7)), noise());
      if ($urandom_range(1)) send_beat(samc_pkg::OP_STOP, noise());
    end
  endtask

  task automatic random_phase(int cnt);
    int stop_at;
    stop_at = n_items + cnt;
    while (n_items < stop_at) scenario();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    // start from the reset values, written explicitly
    set_all(10, 4000, 1000, 50, 200, 1, 100000, 0);

    // directed part
    calm = 1;
    send_beat(samc_pkg::OP_STOP, noise());
    jog(3);                       // below minimum speed, raised
    tick(1); tick(1);
    jog(-32768);                  // above maximum, lowered
    tick(1);
    jog(0);
    tick(1);
    goto_pos(40, 0);              // from below, default speed
    repeat (3) tick(1);
    goto_pos(-20, 32767);         // from above: overshoot first
    repeat (3) tick(1);
    goto_pos($signed(sb.pos), 5); // already there
    goto_pos(32'sh8000_0000, 1);  // overshoot saturates
    send_beat(samc_pkg::OP_HOME, noise());
    jog(100);                     // refused while homing
    goto_pos(10, 100);            // accepted alongside homing
    tick(1);
    tick(0);                      // endstop hit
    send_beat(3'd5, noise());     // unused codes
    send_beat(3'd6, noise());
    send_beat(3'd7, noise());
    t_now = 32'hFFFF_FF00;        // time wrap on the next ticks
    jog(2000);
    tick(1); tick(1);
    calm = 0;

    // long receiver hold-off while commands keep coming
    hold_req = 1;
    random_phase(130);
    drain();                      // sender waits for every result

    set_all(0, 32767, 32767, 65535, 32767, 0, 1, 1);
    random_phase(130);
    drain();

    set_all(32767, 1, 1, 0, 1, 1, 32'h7FFF_FFFF, 0);
    random_phase(100);
    drain();

    set_all(20, 3000, 500, 7, 600, 0, 25, 1);
    calm = 1;
    random_phase(60);
    calm = 0;
    random_phase(80);
    drain();

    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
